// File: hw/rtl/mrc_pkg.sv
// shared constants, codes and sigmoid table for the two-class perceptron classifier
`timescale 1ns / 1ps
package mrc_pkg;

  // network dimensions
  localparam int INPUT_LEN = 128;
  localparam int HIDDEN1   = 64;
  localparam int HIDDEN2   = 32;
  localparam int OUTPUTS   = 2;

  // store sizes
  localparam int W1_N = INPUT_LEN * HIDDEN1;
  localparam int W2_N = HIDDEN1 * HIDDEN2;
  localparam int W3_N = HIDDEN2 * OUTPUTS;
  localparam int B_N  = HIDDEN1 + HIDDEN2 + OUTPUTS;

  // address widths
  localparam int W1_AW   = $clog2(W1_N);
  localparam int W2_AW   = $clog2(W2_N > 1 ? W2_N : 2);
  localparam int W3_AW   = $clog2(W3_N);
  localparam int WA_W    = (W1_AW > W2_AW) ? ((W1_AW > W3_AW) ? W1_AW : W3_AW)
                                           : ((W2_AW > W3_AW) ? W2_AW : W3_AW);
  localparam int B_AW    = $clog2(B_N);
  localparam int SAMP_AW = $clog2(INPUT_LEN);
  localparam int H1_AW   = $clog2(HIDDEN1 > 1 ? HIDDEN1 : 2);
  localparam int H2_AW   = $clog2(HIDDEN2 > 1 ? HIDDEN2 : 2);
  localparam int MAX_DIM = (INPUT_LEN > HIDDEN1) ?
                           ((INPUT_LEN > HIDDEN2) ? INPUT_LEN : HIDDEN2) :
                           ((HIDDEN1 > HIDDEN2) ? HIDDEN1 : HIDDEN2);
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int SCNT_W  = $clog2(INPUT_LEN + 1);

  // arithmetic widths
  localparam int ACC_W  = 48;
  localparam int X_W    = 32;
  localparam int WGT_W  = 16;
  localparam int Q_SH   = 12;
  localparam int DIFF_W = 33;
  localparam logic signed [DIFF_W-1:0] DIFF_LIMIT = 33'sd524288;

  // request function codes
  localparam logic [1:0] FUNC_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_BIAS   = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;

  // layer codes
  localparam logic [1:0] LAYER_ONE = 2'd0;
  localparam logic [1:0] LAYER_TWO = 2'd1;
  localparam logic [1:0] LAYER_OUT = 2'd2;

  // control from sequencer to the mac unit
  typedef struct packed {
    logic clr;
    logic mul_v;
    logic bias_v;
  } mac_ctl_t;

  // sigmoid table, built at elaboration
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] R_Q30   = 64'd1040706261;   // e^-1/32 in Q30

  typedef logic [15:0] sig_tab_t [256];

  function automatic sig_tab_t sig_build();
    sig_tab_t    t;
    logic [63:0] r2;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] trial;
    logic [63:0] hi;
    r2 = (R_Q30 * R_Q30 + (Q30_ONE >> 1)) >> 30;
    e  = R_Q30;
    for (int j = 0; j < 128; j++) begin
      den = Q30_ONE + e;
      num = (e << 16) + (den >> 1);
      q   = 64'd0;
      // restoring quotient search, one bit a step
      for (int b = 16; b >= 0; b--) begin
        trial = q | (64'd1 << b);
        if (trial * den <= num) q = trial;
      end
      hi = 64'd65536 - q;
      t[127-j] = q[15:0];
      t[128+j] = hi[15:0];
      e = (e * r2 + (Q30_ONE >> 1)) >> 30;
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TABLE = sig_build();

endpackage

// File: hw/rtl/mrc_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps
interface mrc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [1:0]         layer;
  logic [12:0]        index;
  logic signed [15:0] value;
  logic               last;
  modport source (output valid, func, layer, index, value, last, input ready);
  modport sink   (input valid, func, layer, index, value, last, output ready);
endinterface

interface mrc_out_if;
  logic        valid;
  logic        ready;
  logic        decision;
  logic [15:0] prob_first;
  logic [15:0] prob_second;
  modport source (output valid, decision, prob_first, prob_second, input ready);
  modport sink   (input valid, decision, prob_first, prob_second, output ready);
endinterface

// File: hw/rtl/mrc_mac.sv
// shared multiply-accumulate unit with 48-bit saturation and q16 conversion
`timescale 1ns / 1ps
module mrc_mac
  import mrc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctl_t                ctl,
  input  logic signed [X_W-1:0]   x,
  input  logic signed [WGT_W-1:0] w,
  input  logic signed [WGT_W-1:0] bias,
  output logic                    busy,
  output logic signed [31:0]      q16
);

  logic signed [ACC_W-1:0] prod_r;
  logic                    prod_v_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] addend;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] sum_sat;
  logic signed [ACC_W-1:0] shifted;

  // product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.mul_v;
    end
    if (ctl.mul_v) begin
      prod_r <= ACC_W'(x * w);
    end
  end

  // saturating add of product or scaled bias
  always_comb begin
    addend = ctl.bias_v ? ACC_W'($signed({bias, 16'h0000})) : prod_r;
    sum    = {acc_r[ACC_W-1], acc_r} + {addend[ACC_W-1], addend};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sum_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.bias_v || prod_v_r) begin
      acc_r <= sum_sat;
    end
  end

  // floor shift to q16, clamp to 32 bits
  always_comb begin
    shifted = acc_r >>> Q_SH;
    if (shifted > 48'sh0000_7FFF_FFFF) begin
      q16 = 32'sh7FFF_FFFF;
    end else if (shifted < -48'sh0000_8000_0000) begin
      q16 = 32'sh8000_0000;
    end else begin
      q16 = shifted[31:0];
    end
  end

  assign busy = prod_v_r;

endmodule

// File: hw/rtl/mlp_relu_two_class_classifier.sv
// top level: weight stores, sample window, layer sequencer and softmax output
//
// Requests come in on in_req. func selects a weight write, a bias write or a
// sample; weight and bias writes and ordinary samples are accepted while the
// sequencer is idle. A sample marked last closes the window and starts
// inference: three layers run on one shared multiply-accumulate unit, one
// product per cycle while a neuron's inputs stream. Each neuron goes through
// setup, its products, a multiplier drain, the bias add and write-back.
// The rate is set by the single multiplier and the one read port of each
// weight store. in_req.ready is low for the whole inference.
// One result per window leaves on out_res: the class decision and both
// probabilities from the sigmoid table. The result sits in an output
// register; if the receiver stalls, it is held, and a following window waits
// to deliver until the register is free.
// Reset clears the sample count, the sequencer and the output valid; the
// weight, bias and sample stores must be written before they are used.
`timescale 1ns / 1ps
module mlp_relu_two_class_classifier
  import mrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  mrc_in_if.sink       in_req,
  mrc_out_if.source    out_res
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_RUN, ST_DRAIN, ST_BIAS, ST_FIN, ST_EMIT
  } state_t;

  state_t                  state_r;
  logic [1:0]              layer_r;
  logic [CNT_W-1:0]        i_r;
  logic [CNT_W-1:0]        k_r;
  logic [WA_W-1:0]         waddr_r;
  logic [SCNT_W-1:0]       scnt_r;
  logic                    rd_v_r;
  logic signed [31:0]      logit_r [2];
  logic                    out_valid_r;
  logic                    decision_r;
  logic [15:0]             prob_first_r;
  logic [15:0]             prob_second_r;

  // memories and read registers
  logic signed [15:0]      w1_mem [W1_N];
  logic signed [15:0]      w2_mem [W2_N];
  logic signed [15:0]      w3_mem [W3_N];
  logic signed [15:0]      b_mem [B_N];
  logic signed [15:0]      s_mem [INPUT_LEN];
  logic signed [31:0]      h1_mem [HIDDEN1];
  logic signed [31:0]      h2_mem [HIDDEN2];
  logic signed [15:0]      w1_rd_r, w2_rd_r, w3_rd_r, b_rd_r, s_rd_r;
  logic signed [31:0]      h1_rd_r, h2_rd_r;

  logic                    in_fire;
  logic                    rd_en;
  logic                    fin_wr;
  logic [CNT_W-1:0]        n_in;
  logic [CNT_W-1:0]        n_out;
  logic [B_AW-1:0]         b_base;
  logic [B_AW-1:0]         b_waddr;
  logic                    b_wvalid;
  logic                    s_we;
  logic signed [X_W-1:0]   x_sel;
  logic signed [WGT_W-1:0] w_sel;
  logic signed [31:0]      q16;
  logic signed [31:0]      q_act;
  logic                    mac_busy;
  mac_ctl_t                mac_ctl;
  logic signed [DIFF_W-1:0] d_raw;
  logic signed [DIFF_W-1:0] d_clamp;
  logic [DIFF_W-1:0]       d_off;
  logic [7:0]              sig_idx;

  assign in_fire = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == ST_IDLE);
  assign rd_en   = (state_r == ST_RUN);
  assign fin_wr  = (state_r == ST_FIN);

  // layer dimensions
  always_comb begin
    unique case (layer_r)
      LAYER_ONE: begin
        n_in = CNT_W'(INPUT_LEN); n_out = CNT_W'(HIDDEN1); b_base = '0;
      end
      LAYER_TWO: begin
        n_in = CNT_W'(HIDDEN1); n_out = CNT_W'(HIDDEN2); b_base = B_AW'(HIDDEN1);
      end
      default: begin
        n_in = CNT_W'(HIDDEN2); n_out = CNT_W'(OUTPUTS);
        b_base = B_AW'(HIDDEN1 + HIDDEN2);
      end
    endcase
  end

  // bias write decode
  always_comb begin
    b_waddr  = '0;
    b_wvalid = 1'b0;
    unique case (in_req.layer)
      LAYER_ONE: begin
        b_waddr = B_AW'(in_req.index); b_wvalid = 32'(in_req.index) < HIDDEN1;
      end
      LAYER_TWO: begin
        b_waddr  = B_AW'(in_req.index) + B_AW'(HIDDEN1);
        b_wvalid = 32'(in_req.index) < HIDDEN2;
      end
      LAYER_OUT: begin
        b_waddr  = B_AW'(in_req.index) + B_AW'(HIDDEN1 + HIDDEN2);
        b_wvalid = 32'(in_req.index) < OUTPUTS;
      end
      default: begin
        b_wvalid = 1'b0;
      end
    endcase
  end

  assign s_we = in_fire && (in_req.func == FUNC_SAMPLE) && (32'(scnt_r) < INPUT_LEN);

  // weight stores
  always_ff @(posedge clk) begin
    if (in_fire && in_req.func == FUNC_WEIGHT && in_req.layer == LAYER_ONE &&
        32'(in_req.index) < W1_N) begin
      w1_mem[W1_AW'(in_req.index)] <= in_req.value;
    end
    if (rd_en) w1_rd_r <= w1_mem[waddr_r[W1_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_req.func == FUNC_WEIGHT && in_req.layer == LAYER_TWO &&
        32'(in_req.index) < W2_N) begin
      w2_mem[W2_AW'(in_req.index)] <= in_req.value;
    end
    if (rd_en) w2_rd_r <= w2_mem[waddr_r[W2_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_req.func == FUNC_WEIGHT && in_req.layer == LAYER_OUT &&
        32'(in_req.index) < W3_N) begin
      w3_mem[W3_AW'(in_req.index)] <= in_req.value;
    end
    if (rd_en) w3_rd_r <= w3_mem[waddr_r[W3_AW-1:0]];
  end

  // bias store, read once per neuron
  always_ff @(posedge clk) begin
    if (in_fire && in_req.func == FUNC_BIAS && b_wvalid) begin
      b_mem[b_waddr] <= in_req.value;
    end
    if (state_r == ST_START) b_rd_r <= b_mem[b_base + B_AW'(k_r)];
  end

  // sample window
  always_ff @(posedge clk) begin
    if (s_we) s_mem[scnt_r[SAMP_AW-1:0]] <= in_req.value;
    if (rd_en) s_rd_r <= s_mem[i_r[SAMP_AW-1:0]];
  end

  // hidden activations
  always_ff @(posedge clk) begin
    if (fin_wr && layer_r == LAYER_ONE) h1_mem[k_r[H1_AW-1:0]] <= q_act;
    if (rd_en) h1_rd_r <= h1_mem[i_r[H1_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (fin_wr && layer_r == LAYER_TWO) h2_mem[k_r[H2_AW-1:0]] <= q_act;
    if (rd_en) h2_rd_r <= h2_mem[i_r[H2_AW-1:0]];
  end

  // operand select; samples scaled by ten
  always_comb begin
    unique case (layer_r)
      LAYER_ONE: begin
        x_sel = (X_W'(s_rd_r) <<< 3) + (X_W'(s_rd_r) <<< 1);
        w_sel = w1_rd_r;
      end
      LAYER_TWO: begin
        x_sel = h1_rd_r; w_sel = w2_rd_r;
      end
      default: begin
        x_sel = h2_rd_r; w_sel = w3_rd_r;
      end
    endcase
  end

  assign mac_ctl.clr    = (state_r == ST_START);
  assign mac_ctl.mul_v  = rd_v_r;
  assign mac_ctl.bias_v = (state_r == ST_BIAS);

  mrc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .x     (x_sel),
    .w     (w_sel),
    .bias  (b_rd_r),
    .busy  (mac_busy),
    .q16   (q16)
  );

  // relu on hidden layers
  assign q_act = (layer_r != LAYER_OUT && q16 < 0) ? 32'sd0 : q16;

  // logit difference to table index
  always_comb begin
    d_raw = DIFF_W'(logit_r[1]) - DIFF_W'(logit_r[0]);
    if (d_raw > DIFF_LIMIT - 33'sd1) begin
      d_clamp = DIFF_LIMIT - 33'sd1;
    end else if (d_raw < -DIFF_LIMIT) begin
      d_clamp = -DIFF_LIMIT;
    end else begin
      d_clamp = d_raw;
    end
    d_off   = DIFF_W'(d_clamp + DIFF_LIMIT);
    sig_idx = d_off[19:12];
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      layer_r     <= LAYER_ONE;
      i_r         <= '0;
      k_r         <= '0;
      waddr_r     <= '0;
      scnt_r      <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r <= rd_en;
      // the emit step reloads the register itself
      if (out_valid_r && out_res.ready && state_r != ST_EMIT) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && in_req.func == FUNC_SAMPLE) begin
            if (in_req.last) begin
              scnt_r  <= '0;
              layer_r <= LAYER_ONE;
              k_r     <= '0;
              state_r <= ST_START;
            end else if (s_we) begin
              scnt_r <= scnt_r + SCNT_W'(1);
            end
          end
        end
        ST_START: begin
          i_r     <= '0;
          waddr_r <= WA_W'(k_r);
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          i_r     <= i_r + CNT_W'(1);
          waddr_r <= waddr_r + WA_W'(n_out);
          if (i_r == n_in - CNT_W'(1)) state_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!rd_v_r && !mac_busy) state_r <= ST_BIAS;
        end
        ST_BIAS: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (layer_r == LAYER_OUT) logit_r[k_r[0]] <= q_act;
          if (k_r == n_out - CNT_W'(1)) begin
            k_r <= '0;
            if (layer_r == LAYER_OUT) begin
              state_r <= ST_EMIT;
            end else begin
              layer_r <= layer_r + 2'd1;
              state_r <= ST_START;
            end
          end else begin
            k_r     <= k_r + CNT_W'(1);
            state_r <= ST_START;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_res.ready) begin
            out_valid_r   <= 1'b1;
            decision_r    <= (logit_r[1] >= logit_r[0]);
            prob_first_r  <= SIG_TABLE[8'd255 - sig_idx];
            prob_second_r <= SIG_TABLE[sig_idx];
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.decision    = decision_r;
  assign out_res.prob_first  = prob_first_r;
  assign out_res.prob_second = prob_second_r;

  // a new result only comes from the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result loaded outside emit");

  // class agrees with the second probability
  a_decision: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (decision_r == (prob_second_r >= 16'h8000)))
    else $error("decision disagrees with probability");

  // probabilities add up to one
  a_prob_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (16'(prob_first_r + prob_second_r) == 16'h0000))
    else $error("probabilities do not sum to one");

  // neuron counter stays inside the layer
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN || state_r == ST_FIN) |-> (k_r < n_out))
    else $error("neuron counter out of range");

  // the mac unit is drained before the bias is added
  a_bias_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BIAS) |-> (!mac_busy && !rd_v_r))
    else $error("bias added while products in flight");

endmodule

// File: tb/mlp_relu_two_class_classifier_tb.sv
// self-checking testbench for the two-class perceptron classifier
`timescale 1ns / 1ps
module mlp_relu_two_class_classifier_tb;
  import mrc_pkg::*;

  localparam logic [1:0] FUNC_NONE  = 2'd3;
  localparam logic [1:0] LAYER_NONE = 2'd3;
  localparam longint ACC_HI = 64'sd140737488355327;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint DIFF_LIM = 524288;
  localparam longint unsigned Q30 = 64'd1073741824;
  localparam int CYCLE_LIMIT = 100_000_000;
  localparam int DRAIN_CYCLES = 12000;

  typedef struct {
    logic        decision;
    logic [15:0] prob_first;
    logic [15:0] prob_second;
  } class_result_t;

  logic clk;
  logic rst_n;
  mrc_in_if  req_if();
  mrc_out_if res_if();

  mlp_relu_two_class_classifier dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_res(res_if)
  );

  // predictor state
  logic signed [15:0] w_one [W1_N];
  logic signed [15:0] w_two [W2_N];
  logic signed [15:0] w_out [W3_N];
  logic signed [15:0] bias_mem [B_N];
  logic signed [15:0] window [INPUT_LEN];
  int unsigned        window_fill;
  logic [15:0]        sigmoid_lut [256];
  class_result_t      pending_results [$];

  int in_idle_pct;
  int out_idle_pct;
  int fail_count;
  int cycle_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // global timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** mlp_relu_two_class_classifier: FAILED **");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // sigmoid lookup from e^-1/32 in q30
  function automatic void build_sigmoid();
    longint          s;
    longint unsigned term, r, r2, e, den, lo;
    s = Q30;
    term = Q30;
    for (int n = 1; n <= 7; n++) begin
      term = term / longint'(32 * n);
      if (n % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    r  = s;
    r2 = (r * r + (Q30 >> 1)) >> 30;
    e  = r;
    for (int j = 0; j < 128; j++) begin
      den = Q30 + e;
      lo  = (e * 65536 + (den >> 1)) / den;
      sigmoid_lut[127 - j] = lo[15:0];
      sigmoid_lut[128 + j] = 16'(65536 - lo);
      e = (e * r2 + (Q30 >> 1)) >> 30;
    end
  endfunction

  function automatic longint clamp48(longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  function automatic int acc_to_fixed(longint acc);
    longint q;
    q = acc >>> 12;
    if (q > 64'sd2147483647) return 32'sh7fffffff;
    if (q < -64'sd2147483648) return 32'sh80000000;
    return int'(q);
  endfunction

  // full forward pass over the current window
  function automatic class_result_t classify_window();
    int            xin [INPUT_LEN];
    int            h1 [HIDDEN1];
    int            h2 [HIDDEN2];
    int            logit [OUTPUTS];
    longint        acc;
    longint        d;
    int            q;
    int unsigned   n;
    class_result_t res;
    for (int i = 0; i < INPUT_LEN; i++) xin[i] = int'(window[i]) * 10;
    for (int k = 0; k < HIDDEN1; k++) begin
      acc = 0;
      for (int i = 0; i < INPUT_LEN; i++)
        acc = clamp48(acc + longint'(xin[i]) * longint'(w_one[i * HIDDEN1 + k]));
      acc = clamp48(acc + longint'(bias_mem[k]) * 65536);
      q = acc_to_fixed(acc);
      h1[k] = (q < 0) ? 0 : q;
    end
    for (int k = 0; k < HIDDEN2; k++) begin
      acc = 0;
      for (int i = 0; i < HIDDEN1; i++)
        acc = clamp48(acc + longint'(h1[i]) * longint'(w_two[i * HIDDEN2 + k]));
      acc = clamp48(acc + longint'(bias_mem[HIDDEN1 + k]) * 65536);
      q = acc_to_fixed(acc);
      h2[k] = (q < 0) ? 0 : q;
    end
    for (int k = 0; k < OUTPUTS; k++) begin
      acc = 0;
      for (int i = 0; i < HIDDEN2; i++)
        acc = clamp48(acc + longint'(h2[i]) * longint'(w_out[i * OUTPUTS + k]));
      acc = clamp48(acc + longint'(bias_mem[HIDDEN1 + HIDDEN2 + k]) * 65536);
      logit[k] = acc_to_fixed(acc);
    end
    d = longint'(logit[1]) - longint'(logit[0]);
    if (d > DIFF_LIM - 1) d = DIFF_LIM - 1;
    if (d < -DIFF_LIM) d = -DIFF_LIM;
    n = int'((d + DIFF_LIM) >>> 12) & 255;
    res.decision    = (logit[1] >= logit[0]);
    res.prob_first  = sigmoid_lut[255 - n];
    res.prob_second = sigmoid_lut[n];
    return res;
  endfunction

  // update predictor with one accepted request
  function automatic void predict_request(logic [1:0] f, logic [1:0] l, logic [12:0] idx,
                                          logic signed [15:0] v, logic lst);
    if (f == FUNC_WEIGHT) begin
      if (l == LAYER_ONE && idx < W1_N) w_one[idx] = v;
      else if (l == LAYER_TWO && idx < W2_N) w_two[idx] = v;
      else if (l == LAYER_OUT && idx < W3_N) w_out[idx] = v;
    end else if (f == FUNC_BIAS) begin
      if (l == LAYER_ONE && idx < HIDDEN1) bias_mem[idx] = v;
      else if (l == LAYER_TWO && idx < HIDDEN2) bias_mem[HIDDEN1 + idx] = v;
      else if (l == LAYER_OUT && idx < OUTPUTS) bias_mem[HIDDEN1 + HIDDEN2 + idx] = v;
    end else if (f == FUNC_SAMPLE) begin
      if (window_fill < INPUT_LEN) begin
        window[window_fill] = v;
        window_fill++;
      end
      if (lst) begin
        window_fill = 0;
        pending_results.push_back(classify_window());
      end
    end
  endfunction

  // drive one request and wait for it to be taken
  task automatic send_request(logic [1:0] f, logic [1:0] l, logic [12:0] idx,
                              logic signed [15:0] v, logic lst);
    if ($urandom_range(99) < in_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.func  <= f;
    req_if.layer <= l;
    req_if.index <= idx;
    req_if.value <= v;
    req_if.last  <= lst;
    forever begin
      @(negedge clk);
      if (req_if.ready) break;
    end
    @(posedge clk);
    predict_request(f, l, idx, v, lst);
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] small_weight();
    return 16'($signed($urandom_range(0, 1023)) - 512);
  endfunction

  // check each result against the oldest expectation
  always @(negedge clk) begin
    class_result_t exp_res;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result decision=%0d", res_if.decision);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (res_if.decision !== exp_res.decision) begin
          $error("decision: expected %0d, got %0d", exp_res.decision, res_if.decision);
          fail_count++;
        end
        if (res_if.prob_first !== exp_res.prob_first) begin
          $error("prob_first: expected %0d, got %0d", exp_res.prob_first,
                 res_if.prob_first);
          fail_count++;
        end
        if (res_if.prob_second !== exp_res.prob_second) begin
          $error("prob_second: expected %0d, got %0d", exp_res.prob_second,
                 res_if.prob_second);
          fail_count++;
        end
      end
    end
  end

  // fill every weight and bias entry, then send one full window of samples
  task automatic test_full_load();
    for (int i = 0; i < W1_N; i++) send_request(FUNC_WEIGHT, LAYER_ONE, 13'(i), small_weight(), 1'b0);
    for (int i = 0; i < W2_N; i++) send_request(FUNC_WEIGHT, LAYER_TWO, 13'(i), small_weight(), 1'b0);
    for (int i = 0; i < W3_N; i++) send_request(FUNC_WEIGHT, LAYER_OUT, 13'(i), small_weight(), 1'b0);
    for (int i = 0; i < HIDDEN1; i++) send_request(FUNC_BIAS, LAYER_ONE, 13'(i), small_weight(), 1'b0);
    for (int i = 0; i < HIDDEN2; i++) send_request(FUNC_BIAS, LAYER_TWO, 13'(i), small_weight(), 1'b0);
    for (int i = 0; i < OUTPUTS; i++) send_request(FUNC_BIAS, LAYER_OUT, 13'(i), small_weight(), 1'b0);
    for (int i = 0; i < INPUT_LEN; i++)
      send_request(FUNC_SAMPLE, LAYER_ONE, 13'($urandom), 16'($urandom), i == INPUT_LEN - 1);
  endtask

  // ignored requests, edge indexes and extreme values
  task automatic test_edge_requests();
    send_request(FUNC_NONE, LAYER_ONE, 13'd0, 16'sh7fff, 1'b1);
    send_request(FUNC_WEIGHT, LAYER_NONE, 13'd0, 16'sh7fff, 1'b0);
    send_request(FUNC_BIAS, LAYER_NONE, 13'd0, 16'sh8000, 1'b0);
    send_request(FUNC_WEIGHT, LAYER_TWO, 13'(W2_N), 16'sh7fff, 1'b0);
    send_request(FUNC_WEIGHT, LAYER_OUT, 13'(W3_N), 16'sh7fff, 1'b0);
    send_request(FUNC_WEIGHT, LAYER_OUT, 13'h1fff, 16'sh7fff, 1'b0);
    send_request(FUNC_BIAS, LAYER_ONE, 13'(HIDDEN1), 16'sh7fff, 1'b0);
    send_request(FUNC_BIAS, LAYER_TWO, 13'(HIDDEN2), 16'sh7fff, 1'b0);
    send_request(FUNC_BIAS, LAYER_OUT, 13'(OUTPUTS), 16'sh7fff, 1'b0);
    // last on a weight write is not a window end
    send_request(FUNC_WEIGHT, LAYER_ONE, 13'h1fff, 16'sh8000, 1'b1);
    send_request(FUNC_WEIGHT, LAYER_ONE, 13'd0, 16'sh7fff, 1'b0);
    send_request(FUNC_WEIGHT, LAYER_OUT, 13'd0, 16'sh7fff, 1'b0);
    send_request(FUNC_BIAS, LAYER_OUT, 13'd1, 16'sh8000, 1'b1);
    send_request(FUNC_BIAS, LAYER_OUT, 13'd0, 16'sh7fff, 1'b0);
    // short window with extreme samples, saturating accumulators
    send_request(FUNC_SAMPLE, LAYER_ONE, 13'd0, 16'sh7fff, 1'b0);
    send_request(FUNC_SAMPLE, LAYER_ONE, 13'h1fff, 16'sh8000, 1'b0);
    send_request(FUNC_SAMPLE, LAYER_NONE, 13'd0, 16'sh0000, 1'b1);
    send_request(FUNC_SAMPLE, LAYER_ONE, 13'd0, 16'shffff, 1'b1);
  endtask

  // window longer than the buffer; extra samples are dropped
  task automatic test_window_overflow();
    for (int i = 0; i < INPUT_LEN + 5; i++)
      send_request(FUNC_SAMPLE, LAYER_ONE, 13'd0, 16'($urandom), i == INPUT_LEN + 4);
    // pause until the classifier has answered
    wait_results_drained();
  endtask

  // mixed random traffic: windows, weight rewrites, noise
  task automatic test_random_traffic(int n_items);
    int          kind;
    logic [1:0]  l;
    logic [12:0] idx;
    for (int n = 0; n < n_items; n++) begin
      kind = $urandom_range(99);
      l    = 2'($urandom_range(0, 2));
      if (kind < 60) begin
        send_request(FUNC_SAMPLE, 2'($urandom), 13'($urandom), 16'($urandom),
                     $urandom_range(24) == 0);
      end else if (kind < 85) begin
        idx = (l == LAYER_ONE) ? 13'($urandom_range(W1_N - 1)) :
              (l == LAYER_TWO) ? 13'($urandom_range(W2_N - 1)) : 13'($urandom_range(W3_N - 1));
        send_request(FUNC_WEIGHT, l, idx,
                     ($urandom_range(9) == 0) ? 16'($urandom) : small_weight(), 1'($urandom));
      end else if (kind < 93) begin
        idx = (l == LAYER_ONE) ? 13'($urandom_range(HIDDEN1 - 1)) :
              (l == LAYER_TWO) ? 13'($urandom_range(HIDDEN2 - 1)) : 13'($urandom_range(OUTPUTS - 1));
        send_request(FUNC_BIAS, l, idx,
                     ($urandom_range(9) == 0) ? 16'($urandom) : small_weight(), 1'($urandom));
      end else begin
        kind = $urandom_range(2);
        if (kind == 0)
          send_request(FUNC_NONE, 2'($urandom), 13'($urandom), 16'($urandom), 1'($urandom));
        else if (kind == 1)
          send_request(2'($urandom_range(1)), LAYER_NONE, 13'($urandom), 16'($urandom), 1'b0);
        else
          send_request(2'($urandom_range(1)), 2'($urandom_range(1, 2)),
                       13'($urandom_range(W3_N, 8191)), 16'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    fail_count   = 0;
    cycle_count  = 0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    window_fill  = 0;
    build_sigmoid();
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.func  = FUNC_WEIGHT;
    req_if.layer = LAYER_ONE;
    req_if.index = '0;
    req_if.value = '0;
    req_if.last  = 1'b0;
    res_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_load();
    in_idle_pct  = 21;
    out_idle_pct = 81;
    test_edge_requests();
    test_window_overflow();
    test_random_traffic(500);
    in_idle_pct  = 81;
    out_idle_pct = 21;
    test_random_traffic(500);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_traffic(500);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("** mlp_relu_two_class_classifier: PASSED **");
    end else begin
      $display("** mlp_relu_two_class_classifier: FAILED **");
    end
    $finish;
  end

endmodule
